### src/oasc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oasc_pkg: shared types and constants of the obstacle avoid speed controller
// Holds field widths, command codes, register indexes, reset values and the
// result and configuration structs that travel between modules.
// ----------------------------------------------------------------------------
package oasc_pkg;

  // Datapath widths
  localparam int DIST_W  = 16;
  localparam int SPEED_W = 10;
  localparam int SUM_W   = SPEED_W + 1;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 16;

  typedef logic [DIST_W-1:0]  dist_t;
  typedef logic [SPEED_W-1:0] speed_t;
  typedef logic [9:0]         cfg_speed_t;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_OBSTACLE_LIMIT = 4'd0;
  localparam logic [IDX_W-1:0] REG_FAR_LIMIT      = 4'd1;
  localparam logic [IDX_W-1:0] REG_NEAR_LIMIT     = 4'd2;
  localparam logic [IDX_W-1:0] REG_SPEED_FLOOR    = 4'd3;
  localparam logic [IDX_W-1:0] REG_SPEED_CAP      = 4'd4;
  localparam logic [IDX_W-1:0] REG_TURN_SPEED     = 4'd5;
  localparam logic [IDX_W-1:0] REG_STEP_DOWN      = 4'd6;
  localparam logic [IDX_W-1:0] REG_STEP_UP        = 4'd7;

  // Register reset values
  localparam logic [15:0] RST_OBSTACLE_LIMIT = 16'd500;
  localparam logic [15:0] RST_FAR_LIMIT      = 16'd1500;
  localparam logic [15:0] RST_NEAR_LIMIT     = 16'd1000;
  localparam cfg_speed_t  RST_SPEED_FLOOR    = 10'd400;
  localparam cfg_speed_t  RST_SPEED_CAP      = 10'd800;
  localparam cfg_speed_t  RST_TURN_SPEED     = 10'd600;
  localparam cfg_speed_t  RST_STEP_DOWN      = 10'd40;
  localparam cfg_speed_t  RST_STEP_UP        = 10'd100;
  localparam speed_t      RST_SPEED          = SPEED_W'(400);

  // Command codes
  localparam logic       KIND_MOTOR    = 1'b0;
  localparam logic       KIND_SERVO    = 1'b1;
  localparam logic [2:0] DIR_FORWARD   = 3'd0;
  localparam logic [2:0] DIR_BACKWARD  = 3'd1;
  localparam logic [2:0] DIR_STOP      = 3'd2;
  localparam logic [2:0] DIR_LEFT      = 3'd3;
  localparam logic [2:0] DIR_RIGHT     = 3'd4;
  localparam logic [1:0] SERVO_RIGHT   = 2'd0;
  localparam logic [1:0] SERVO_CENTRE  = 2'd1;
  localparam logic [1:0] SERVO_LEFT    = 2'd2;

  typedef enum logic [2:0] {
    MODE_CRUISE     = 3'b001,
    MODE_SCAN_RIGHT = 3'b010,
    MODE_SCAN_LEFT  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [15:0] obstacle_limit;
    logic [15:0] far_limit;
    logic [15:0] near_limit;
    cfg_speed_t  speed_floor;
    cfg_speed_t  speed_cap;
    cfg_speed_t  turn_speed;
    cfg_speed_t  step_down;
    cfg_speed_t  step_up;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] dir;
    logic [9:0] speed;
    logic [1:0] servo;
    logic       last;
  } result_t;

  // One burst of up to three results caused by a single reading
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } burst_t;

  function automatic result_t make_result(logic kind, logic [2:0] dir, logic [9:0] speed,
                                          logic [1:0] servo, logic last);
    result_t r;
    r.kind  = kind;
    r.dir   = dir;
    r.speed = speed;
    r.servo = servo;
    r.last  = last;
    return r;
  endfunction

endpackage
`default_nettype wire

### src/obstacle_avoid_speed_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// obstacle_avoid_speed_controller: distance-driven motor and servo commands
// A reading passes the oasc_step hold register, then the oasc_burst result register,
// before its first result can transfer; results leave one per cycle while the sink
// holds ready high, and each reading yields 1 to 3 results, set by its result count.
// Synchronous reset: cruise mode, speed 400, stored readings zero, no output.
// ----------------------------------------------------------------------------
module obstacle_avoid_speed_controller (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [15:0]                 distance_reading,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        command_kind,
  output logic [2:0]                  motor_direction,
  output logic [9:0]                  motor_speed,
  output logic [1:0]                  servo_position,
  output logic                        last_of_run,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [oasc_pkg::IDX_W-1:0]  cfg_index,
  input  wire  [oasc_pkg::DATA_W-1:0] cfg_data
);
  import oasc_pkg::*;

  cfg_t    cfg;
  burst_t  burst;
  logic    burst_load;
  logic    burst_ready;
  result_t result;

  oasc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  oasc_step u_step (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .distance_reading (distance_reading),
    .cfg              (cfg),
    .burst_ready      (burst_ready),
    .burst_load       (burst_load),
    .burst            (burst)
  );

  oasc_burst u_burst (
    .clk         (clk),
    .rst         (rst),
    .burst_load  (burst_load),
    .burst       (burst),
    .burst_ready (burst_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  // Split the result onto its field ports
  assign command_kind    = result.kind;
  assign motor_direction = result.dir;
  assign motor_speed     = result.speed;
  assign servo_position  = result.servo;
  assign last_of_run     = result.last;

endmodule
`default_nettype wire

### src/oasc_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oasc_cfg_regs: configuration register file
// Takes one register write per cycle by index; indexes past the list drop.
// ----------------------------------------------------------------------------
module oasc_cfg_regs (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [oasc_pkg::IDX_W-1:0]  cfg_index,
  input  wire  [oasc_pkg::DATA_W-1:0] cfg_data,
  output oasc_pkg::cfg_t              cfg
);
  import oasc_pkg::*;

  assign cfg_ready = 1'b1;

  // Write the addressed register on a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.obstacle_limit <= RST_OBSTACLE_LIMIT;
      cfg.far_limit      <= RST_FAR_LIMIT;
      cfg.near_limit     <= RST_NEAR_LIMIT;
      cfg.speed_floor    <= RST_SPEED_FLOOR;
      cfg.speed_cap      <= RST_SPEED_CAP;
      cfg.turn_speed     <= RST_TURN_SPEED;
      cfg.step_down      <= RST_STEP_DOWN;
      cfg.step_up        <= RST_STEP_UP;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OBSTACLE_LIMIT: cfg.obstacle_limit <= cfg_data;
        REG_FAR_LIMIT:      cfg.far_limit      <= cfg_data;
        REG_NEAR_LIMIT:     cfg.near_limit     <= cfg_data;
        REG_SPEED_FLOOR:    cfg.speed_floor    <= cfg_data[9:0];
        REG_SPEED_CAP:      cfg.speed_cap      <= cfg_data[9:0];
        REG_TURN_SPEED:     cfg.turn_speed     <= cfg_data[9:0];
        REG_STEP_DOWN:      cfg.step_down      <= cfg_data[9:0];
        REG_STEP_UP:        cfg.step_up        <= cfg_data[9:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

### src/oasc_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oasc_step: input register and per-reading decision logic
// Registers a reading, then in one pass updates mode and speed state and
// builds the burst of commands that the reading causes.
// ----------------------------------------------------------------------------
module oasc_step (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [15:0]                distance_reading,
  input  wire  oasc_pkg::cfg_t       cfg,
  input  wire                        burst_ready,
  output logic                       burst_load,
  output oasc_pkg::burst_t           burst
);
  import oasc_pkg::*;

  logic   hold_valid;
  dist_t  hold_dist;
  mode_t  mode;
  mode_t  mode_next;
  speed_t current_speed;
  speed_t speed_next;
  dist_t  previous_reading;
  dist_t  right_reading;

  logic             changed;
  logic [SUM_W-1:0] spd_ext;
  logic [SUM_W-1:0] up_ext;
  logic [SUM_W-1:0] down_ext;
  logic [SUM_W-1:0] floor_ext;
  logic [SUM_W-1:0] cap_ext;
  logic [SUM_W-1:0] sum;
  speed_t           spd_dec;
  speed_t           spd_inc;
  logic [2:0]       turn_dir;

  assign in_ready   = !hold_valid || burst_ready;
  assign burst_load = hold_valid && burst_ready;

  // Hold the reading until the burst stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_dist <= distance_reading[DIST_W-1:0];
    end
  end

  // Saturating speed step arithmetic
  always_comb begin
    spd_ext   = {1'b0, current_speed};
    up_ext    = SUM_W'(cfg.step_up);
    down_ext  = SUM_W'(cfg.step_down);
    floor_ext = SUM_W'(cfg.speed_floor);
    cap_ext   = SUM_W'(cfg.speed_cap);
    sum       = spd_ext + up_ext;
    spd_dec   = (spd_ext > down_ext) ? SPEED_W'(spd_ext - down_ext) : '0;
    spd_inc   = sum[SPEED_W] ? {SPEED_W{1'b1}} : sum[SPEED_W-1:0];
    changed   = (hold_dist != previous_reading);
    turn_dir  = (hold_dist < right_reading) ? DIR_LEFT : DIR_RIGHT;
  end

  // Decide the burst and the next state
  always_comb begin
    mode_next  = MODE_CRUISE;
    speed_next = current_speed;
    burst      = '0;
    unique case (mode)
      MODE_SCAN_RIGHT: begin
        mode_next    = MODE_SCAN_LEFT;
        burst.count  = 2'd1;
        burst.res[0] = make_result(KIND_SERVO, DIR_FORWARD, 10'd0, SERVO_LEFT, 1'b1);
      end
      MODE_SCAN_LEFT: begin
        burst.count  = 2'd2;
        burst.res[0] = make_result(KIND_SERVO, DIR_FORWARD, 10'd0, SERVO_CENTRE, 1'b0);
        burst.res[1] = make_result(KIND_MOTOR, turn_dir, cfg.turn_speed, SERVO_RIGHT, 1'b1);
      end
      default: begin
        if (hold_dist > cfg.obstacle_limit) begin
          priority if (hold_dist < cfg.far_limit && hold_dist > cfg.near_limit && changed &&
                       spd_ext >= floor_ext) begin
            speed_next = spd_dec;
          end else if (hold_dist < cfg.near_limit && changed && spd_ext > floor_ext) begin
            speed_next = spd_dec;
          end else if (spd_ext < cap_ext && changed) begin
            speed_next = spd_inc;
          end else begin
            speed_next = current_speed;
          end
          burst.count  = 2'd1;
          burst.res[0] = make_result(KIND_MOTOR, DIR_FORWARD, 10'(speed_next),
                                     SERVO_RIGHT, 1'b1);
        end else begin
          mode_next    = MODE_SCAN_RIGHT;
          burst.count  = 2'd3;
          burst.res[0] = make_result(KIND_MOTOR, DIR_BACKWARD, 10'(current_speed),
                                     SERVO_RIGHT, 1'b0);
          burst.res[1] = make_result(KIND_MOTOR, DIR_STOP, 10'd0, SERVO_RIGHT, 1'b0);
          burst.res[2] = make_result(KIND_SERVO, DIR_FORWARD, 10'd0, SERVO_RIGHT, 1'b1);
        end
      end
    endcase
  end

  // Advance state when the burst is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_CRUISE;
      current_speed    <= RST_SPEED;
      previous_reading <= '0;
      right_reading    <= '0;
    end else if (burst_load) begin
      mode          <= mode_next;
      current_speed <= speed_next;
      if (mode == MODE_SCAN_RIGHT) begin
        right_reading <= hold_dist;
      end else if (mode != MODE_SCAN_LEFT) begin
        previous_reading <= hold_dist;
      end
    end
  end

endmodule
`default_nettype wire

### src/oasc_burst.sv
`default_nettype none
// ----------------------------------------------------------------------------
// oasc_burst: result register and burst sequencer
// Holds up to three results of one reading and presents them one per transfer.
// ----------------------------------------------------------------------------
module oasc_burst (
  input  wire                clk,
  input  wire                rst,
  input  wire                burst_load,
  input  wire oasc_pkg::burst_t burst,
  output logic               burst_ready,
  output logic               out_valid,
  input  wire                out_ready,
  output oasc_pkg::result_t  result
);
  import oasc_pkg::*;

  result_t [2:0] res;
  logic [1:0]    rem;
  logic [1:0]    idx;

  assign out_valid   = (rem != 2'd0);
  assign burst_ready = (rem == 2'd0) || (rem == 2'd1 && out_ready);

  // Select the current result of the burst
  always_comb begin
    unique case (idx)
      2'd1:    result = res[1];
      2'd2:    result = res[2];
      default: result = res[0];
    endcase
  end

  // Load a new burst or advance on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      idx <= 2'd0;
    end else if (burst_load) begin
      rem <= burst.count;
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      rem <= rem - 2'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_load) begin
      res <= burst.res;
    end
  end

endmodule
`default_nettype wire
